// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the pair table.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define BPT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/bpt_pkg.sv =====
// Package of the pair table: command and status codes, defaults, cell control type.
// Depends on nothing; used by bpt_cell and bounded_pair_table.
`default_nettype none

package bpt_pkg;

    localparam int DEFAULT_CAPACITY   = 8;
    localparam int DEFAULT_DATA_WIDTH = 32;

    localparam int FIELD_W = 32;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 4;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_BADIDX = 2'd3;

    typedef struct packed {
        logic live;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/bounded_pair_table.sv =====
// Top level of the pair table: command decode, entry count and the row of cells.
// Depends on bpt_pkg, bpt_cell and assert_macros.svh.
//
//   channel   direction  beat marker        payload
//   command   in         start & !busy      command, key, value, index
//   result    out        done               status, key_out, value_out, count
//   config    in         cfg_wen            cfg_wdata (allow_duplicates)
//
// For every command, done rises in the cycle after the command is
// taken, and busy never rises, so a command may be issued in every cycle.
// Cells compare and shift in parallel, so no command iterates over entries.
// Reset empties the table and sets allow_duplicates; stored pairs are not cleared.
// Results cannot be held off by the receiver.
`default_nettype none

module bounded_pair_table #(
    parameter int CAPACITY   = bpt_pkg::DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = bpt_pkg::DEFAULT_DATA_WIDTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic        [1:0]                     command,
    input  wire logic signed [bpt_pkg::FIELD_W-1:0]    key,
    input  wire logic signed [bpt_pkg::FIELD_W-1:0]    value,
    input  wire logic        [bpt_pkg::IDX_W-1:0]      index,
    input  wire logic                                  cfg_wen,
    input  wire logic                                  cfg_wdata,
    output logic                                       done,
    output logic             [1:0]                     status,
    output logic signed      [bpt_pkg::FIELD_W-1:0]    key_out,
    output logic signed      [bpt_pkg::FIELD_W-1:0]    value_out,
    output logic             [bpt_pkg::CNT_W-1:0]      count
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > bpt_pkg::IDX_W) ? CW : bpt_pkg::IDX_W;

    logic                          allow_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          done_reg;
    logic [1:0]                    status_reg;
    logic [1:0]                    status_next;
    logic [bpt_pkg::FIELD_W-1:0]   key_out_reg;
    logic [bpt_pkg::FIELD_W-1:0]   key_out_next;
    logic [bpt_pkg::FIELD_W-1:0]   value_out_reg;
    logic [bpt_pkg::FIELD_W-1:0]   value_out_next;

    logic                          accept;
    logic [DATA_WIDTH-1:0]         in_key;
    logic [DATA_WIDTH-1:0]         in_value;
    logic [CMPW-1:0]               idx_ext;
    logic [CMPW-1:0]               count_ext;
    logic                          full;
    logic                          dup;
    logic                          bad_idx;
    logic                          add_ok;
    logic                          remove_ok;
    logic [DATA_WIDTH-1:0]         sel_key;
    logic [DATA_WIDTH-1:0]         sel_value;

    bpt_pkg::cell_ctrl_t           ctrl     [CAPACITY];
    logic [DATA_WIDTH-1:0]         cell_key [CAPACITY];
    logic [DATA_WIDTH-1:0]         cell_val [CAPACITY];
    logic [CAPACITY-1:0]           match_vec;
    logic [CAPACITY-1:0]           load_vec;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign in_key    = DATA_WIDTH'($unsigned(key));
    assign in_value  = DATA_WIDTH'($unsigned(value));
    assign idx_ext   = CMPW'(index);
    assign count_ext = CMPW'(count_reg);
    assign full      = (count_reg >= CW'(CAPACITY));
    assign dup       = !allow_reg && (|match_vec);
    assign bad_idx   = (idx_ext >= count_ext) || (idx_ext >= CMPW'(CAPACITY));
    assign add_ok    = accept && (command == bpt_pkg::CMD_ADD) && !full && !dup;
    assign remove_ok = accept && (command == bpt_pkg::CMD_REMOVE) && !bad_idx;

    always_comb
    begin
        sel_key   = '0;
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (idx_ext == CMPW'(i))
            begin
                sel_key   = sel_key | cell_key[i];
                sel_value = sel_value | cell_val[i];
            end
        end
    end

    generate
        for (genvar g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] up_key;
            logic [DATA_WIDTH-1:0] up_value;

            if (g == CAPACITY - 1)
            begin : g_last
                assign up_key   = cell_key[g];
                assign up_value = cell_val[g];
            end
            else
            begin : g_mid
                assign up_key   = cell_key[g+1];
                assign up_value = cell_val[g+1];
            end

            assign ctrl[g].live  = (CW'(g) < count_reg);
            assign ctrl[g].load  = add_ok && (CW'(g) == count_reg);
            assign ctrl[g].shift = remove_ok && (CMPW'(g) >= idx_ext)
                                   && (CMPW'(g + 1) < count_ext);
            assign load_vec[g]   = ctrl[g].load;

            bpt_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl[g]),
                .new_key   (in_key),
                .new_value (in_value),
                .up_key    (up_key),
                .up_value  (up_value),
                .cur_key   (cell_key[g]),
                .cur_value (cell_val[g]),
                .match     (match_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        status_next    = bpt_pkg::ST_OK;
        key_out_next   = '0;
        value_out_next = '0;
        count_next     = count_reg;
        unique case (command)
            bpt_pkg::CMD_ADD:
            begin
                if (full)
                begin
                    status_next = bpt_pkg::ST_FULL;
                end
                else if (dup)
                begin
                    status_next = bpt_pkg::ST_DUP;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            bpt_pkg::CMD_REMOVE, bpt_pkg::CMD_READ:
            begin
                if (bad_idx)
                begin
                    status_next = bpt_pkg::ST_BADIDX;
                end
                else
                begin
                    key_out_next   = bpt_pkg::FIELD_W'(sel_key);
                    value_out_next = bpt_pkg::FIELD_W'(sel_value);
                    if (command == bpt_pkg::CMD_REMOVE)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                status_next = bpt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_reg <= 1'b1;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                allow_reg <= cfg_wdata;
            end
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            key_out_reg   <= key_out_next;
            value_out_reg <= value_out_next;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign key_out   = key_out_reg;
    assign value_out = value_out_reg;
    assign count     = bpt_pkg::CNT_W'(count_reg);

`include "assert_macros.svh"

    `BPT_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `BPT_ASSERT(a_done_follows, clk, rst_n, done_reg |-> $past(accept), "result without a command beat")
    `BPT_ASSERT(a_refused_keeps, clk, rst_n, (done_reg && status_reg != bpt_pkg::ST_OK) |-> count_reg == $past(count_reg), "refused command changed the count")
    `BPT_ASSERT_NEVER(a_one_load, clk, rst_n, !$onehot0(load_vec), "more than one cell loaded")

endmodule

`default_nettype wire

// ===== hdl/bpt_cell.sv =====
// One entry of the pair table: holds a key/value pair, compares it with the
// incoming pair, loads that pair on an add and takes the pair of its upper
// neighbor on a remove. Depends on bpt_pkg.
`default_nettype none

module bpt_cell #(
    parameter int DATA_WIDTH = bpt_pkg::DEFAULT_DATA_WIDTH
) (
    input  wire logic                   clk,
    input  wire bpt_pkg::cell_ctrl_t    ctrl,
    input  wire logic [DATA_WIDTH-1:0]  new_key,
    input  wire logic [DATA_WIDTH-1:0]  new_value,
    input  wire logic [DATA_WIDTH-1:0]  up_key,
    input  wire logic [DATA_WIDTH-1:0]  up_value,
    output logic      [DATA_WIDTH-1:0]  cur_key,
    output logic      [DATA_WIDTH-1:0]  cur_value,
    output logic                        match
);

    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            key_reg   <= up_key;
            value_reg <= up_value;
        end
        else if (ctrl.load)
        begin
            key_reg   <= new_key;
            value_reg <= new_value;
        end
    end

    assign cur_key   = key_reg;
    assign cur_value = value_reg;
    assign match     = ctrl.live && (key_reg == new_key) && (value_reg == new_value);

endmodule

`default_nettype wire

// ===== tb/tb_bounded_pair_table.sv =====
// Self-checking testbench for bounded_pair_table: directed and random command traffic,
// with a shadow copy of the table that predicts every result beat.
// Depends on bpt_pkg and the bounded_pair_table RTL.
`default_nettype none

module tb_bounded_pair_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         FIELD_W     = bpt_pkg::FIELD_W;
    localparam int         IDX_W       = bpt_pkg::IDX_W;
    localparam int         CNT_W       = bpt_pkg::CNT_W;
    localparam logic [1:0] CMD_ADD     = bpt_pkg::CMD_ADD;
    localparam logic [1:0] CMD_REMOVE  = bpt_pkg::CMD_REMOVE;
    localparam logic [1:0] CMD_READ    = bpt_pkg::CMD_READ;
    localparam logic [1:0] ST_OK       = bpt_pkg::ST_OK;
    localparam logic [1:0] ST_FULL     = bpt_pkg::ST_FULL;
    localparam logic [1:0] ST_DUP      = bpt_pkg::ST_DUP;
    localparam logic [1:0] ST_BADIDX   = bpt_pkg::ST_BADIDX;

    localparam int         DEPTH       = bpt_pkg::DEFAULT_CAPACITY;
    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [FIELD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] value;
        logic [CNT_W-1:0]   cnt;
    } table_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic        [1:0]         command = CMD_ADD;
    logic signed [FIELD_W-1:0] key = '0;
    logic signed [FIELD_W-1:0] value = '0;
    logic        [IDX_W-1:0]   index = '0;
    logic                      cfg_wen = 1'b0;
    logic                      cfg_wdata = 1'b0;
    logic                      done;
    logic        [1:0]         status;
    logic signed [FIELD_W-1:0] key_out;
    logic signed [FIELD_W-1:0] value_out;
    logic        [CNT_W-1:0]   count;

    logic [FIELD_W-1:0] shadow_keys [DEPTH];
    logic [FIELD_W-1:0] shadow_values [DEPTH];
    int                 shadow_count = 0;
    bit                 dup_allowed = 1'b1;

    table_result_t      pending_results [$];
    int                 error_count = 0;
    int                 cycle_count = 0;

    bounded_pair_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .key       (key),
        .value     (value),
        .index     (index),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .status    (status),
        .key_out   (key_out),
        .value_out (value_out),
        .count     (count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic table_result_t apply_command(logic [1:0] cmd, logic [FIELD_W-1:0] k,
                                                    logic [FIELD_W-1:0] v,
                                                    logic [IDX_W-1:0] idx);
        table_result_t r;
        bit            found;
        r = '0;
        r.status = ST_OK;
        found = 1'b0;
        case (cmd)
            CMD_ADD:
            begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_keys[i] == k && shadow_values[i] == v)
                        found = 1'b1;
                if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else if (!dup_allowed && found)
                    r.status = ST_DUP;
                else
                begin
                    shadow_keys[shadow_count] = k;
                    shadow_values[shadow_count] = v;
                    shadow_count++;
                end
            end
            CMD_REMOVE, CMD_READ:
            begin
                if (int'(idx) >= shadow_count)
                    r.status = ST_BADIDX;
                else
                begin
                    r.key = shadow_keys[idx];
                    r.value = shadow_values[idx];
                    if (cmd == CMD_REMOVE)
                    begin
                        for (int i = int'(idx); i + 1 < shadow_count; i++)
                        begin
                            shadow_keys[i] = shadow_keys[i + 1];
                            shadow_values[i] = shadow_values[i + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            default: ;
        endcase
        r.cnt = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    function automatic void compare_field(string name, logic [FIELD_W-1:0] expected,
                                          logic [FIELD_W-1:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name,
                     expected, actual);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        table_result_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual status %0d",
                         $realtime, status);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                compare_field("status", 32'(exp_r.status), 32'(status));
                compare_field("key_out", exp_r.key, key_out);
                compare_field("value_out", exp_r.value, value_out);
                compare_field("count", 32'(exp_r.cnt), 32'(count));
            end
        end
    end

    // One command beat: optional idle cycles, then hold start until the block takes it.
    task automatic send_command(logic [1:0] cmd, logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] v,
                                logic [IDX_W-1:0] idx, int gap);
        table_result_t predicted;
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        command = cmd;
        key = k;
        value = v;
        index = idx;
        do @(posedge clk); while (busy !== 1'b0);
        predicted = apply_command(cmd, k, v, idx);
        pending_results = {pending_results, predicted};
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_allow_duplicates(bit allow);
        wait_results_drained();
        @(negedge clk);
        cfg_wen = 1'b1;
        cfg_wdata = allow;
        @(negedge clk);
        cfg_wen = 1'b0;
        dup_allowed = allow;
    endtask

    function automatic logic [FIELD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return WORD_ONES;
            4: return FIELD_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_and_unused();
        send_command(CMD_READ, '0, '0, 3'd0, 0);
        send_command(CMD_REMOVE, '0, '0, 3'd7, 1);
        send_command(CMD_UNUSED, WORD_ONES, WORD_ONES, 3'd7, 0);
    endtask

    task automatic test_fill_and_full();
        send_command(CMD_ADD, WORD_MIN, WORD_MAX, 3'd0, 0);
        send_command(CMD_ADD, WORD_MAX, WORD_MIN, 3'd0, 0);
        send_command(CMD_ADD, WORD_MIN, WORD_MAX, 3'd0, 2);
        send_command(CMD_ADD, '0, '0, 3'd0, 0);
        send_command(CMD_ADD, WORD_ONES, WORD_ONES, 3'd0, 0);
        repeat (3)
            send_command(CMD_ADD, $urandom, $urandom, 3'd0, 0);
        send_command(CMD_ADD, $urandom, $urandom, 3'd0, 0);
        send_command(CMD_READ, '0, '0, 3'd7, 0);
    endtask

    task automatic test_remove_shift();
        send_command(CMD_REMOVE, '0, '0, 3'd0, 0);
        send_command(CMD_READ, '0, '0, 3'd7, 0);
        send_command(CMD_REMOVE, '0, '0, 3'd6, 3);
        send_command(CMD_READ, '0, '0, 3'd0, 0);
    endtask

    // With duplicates rejected, a full table still reports full for a repeated pair.
    task automatic test_duplicate_reject();
        write_allow_duplicates(1'b0);
        send_command(CMD_ADD, WORD_MIN, WORD_MAX, 3'd0, 0);
        send_command(CMD_ADD, 32'd1, 32'd2, 3'd0, 0);
        send_command(CMD_ADD, 32'd3, 32'd4, 3'd0, 0);
        send_command(CMD_ADD, 32'd1, 32'd2, 3'd0, 0);
        send_command(CMD_UNUSED, '0, '0, 3'd0, 0);
    endtask

    task automatic run_random_phase(int n_items, int add_pct, bit bursty);
        logic [1:0]         cmd;
        logic [FIELD_W-1:0] k;
        logic [FIELD_W-1:0] v;
        logic [IDX_W-1:0]   idx;
        int                 gap;
        int                 pick;
        for (int n = 0; n < n_items; n++)
        begin
            if ($urandom_range(0, 99) < add_pct)
                cmd = CMD_ADD;
            else
            begin
                pick = $urandom_range(0, 9);
                cmd = (pick < 4) ? CMD_REMOVE : (pick < 9) ? CMD_READ : CMD_UNUSED;
            end
            if (cmd == CMD_ADD && shadow_count > 0 && $urandom_range(0, 3) == 0)
            begin
                pick = $urandom_range(0, shadow_count - 1);
                k = shadow_keys[pick];
                v = shadow_values[pick];
            end
            else
            begin
                k = pick_word();
                v = pick_word();
            end
            if (shadow_count > 0 && $urandom_range(0, 3) != 0)
                idx = IDX_W'($urandom_range(0, shadow_count - 1));
            else
                idx = IDX_W'($urandom_range(0, 7));
            if (bursty || $urandom_range(0, 2) == 0)
                gap = 0;
            else
                gap = $urandom_range(0, 19);
            send_command(cmd, k, v, idx, gap);
            if ($urandom_range(0, 63) == 0)
                wait_results_drained();
        end
    endtask

    task automatic test_random_traffic();
        int add_pcts [8] = '{70, 30, 50, 85, 20, 50, 60, 40};
        for (int p = 0; p < 8; p++)
        begin
            if (p < 4)
                write_allow_duplicates(p[0]);
            else
                write_allow_duplicates(1'($urandom_range(0, 1)));
            run_random_phase(141, add_pcts[p], p == 2 || p == 5);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty_and_unused();
        test_fill_and_full();
        test_remove_shift();
        test_duplicate_reject();
        test_random_traffic();
        wait_results_drained();
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
